// ===== design/cau_pkg.sv =====
// shared constants and command codes for the complex arithmetic unit
`default_nettype none

package cau_pkg;

   localparam int FRAC_BITS_DEF  = 12;
   localparam int PART_WIDTH_DEF = 16;

   typedef enum logic [2:0] {
      CMD_ADD  = 3'd0,
      CMD_SUB  = 3'd1,
      CMD_MUL  = 3'd2,
      CMD_DIV  = 3'd3,
      CMD_CONJ = 3'd4,
      CMD_MOD  = 3'd5,
      CMD_EQ   = 3'd6
   } cmd_type;

endpackage

`default_nettype wire

// ===== design/complex_arithmetic_unit.sv =====
// Complex arithmetic unit on signed fixed-point parts: add, subtract, multiply, divide,
// conjugate, squared modulus and equality. Fully pipelined: one beat may enter every cycle
// while req_stall is low. Every beat, whatever its command, passes the same registers: the
// operand, product, sum and magnitude stages, the divider, which resolves one quotient bit
// per stage for PART_WIDTH+1 stages after a range-check stage, and the output register, so
// results leave in order. The whole pipeline advances whenever the output register is
// empty or being taken, so req_stall follows rsp_valid and rsp_stall directly.
`default_nettype none

module complex_arithmetic_unit #(
   parameter int PART_WIDTH = cau_pkg::PART_WIDTH_DEF,
   parameter int FRAC_BITS  = cau_pkg::FRAC_BITS_DEF
) (
   input  wire logic                         clock,
   input  wire logic                         reset,
   input  wire logic                         req_valid,
   output logic                              req_stall,
   input  wire logic [2:0]                   req_command,
   input  wire logic signed [PART_WIDTH-1:0] req_a_real,
   input  wire logic signed [PART_WIDTH-1:0] req_a_imag,
   input  wire logic signed [PART_WIDTH-1:0] req_b_real,
   input  wire logic signed [PART_WIDTH-1:0] req_b_imag,
   output logic                              rsp_valid,
   input  wire logic                         rsp_stall,
   output logic signed [PART_WIDTH-1:0]      rsp_res_real,
   output logic signed [PART_WIDTH-1:0]      rsp_res_imag,
   output logic                              rsp_is_equal,
   output logic                              rsp_div_zero,
   output logic                              rsp_overflow
);

   import cau_pkg::*;

   localparam int W    = PART_WIDTH;
   localparam int PW   = 2 * W;
   localparam int SW   = 2 * W + 2;
   localparam int MAGW = 2 * W + 1;
   localparam logic [MAGW-1:0] NEG_LIM = MAGW'(1) << (W - 1);
   localparam logic [MAGW-1:0] POS_LIM = NEG_LIM - MAGW'(1);

   typedef struct packed {
      logic            is_div;
      logic            eq;
      logic            dz;
      logic            neg_re;
      logic            neg_im;
      logic [MAGW-1:0] mag_re;
      logic [MAGW-1:0] mag_im;
   } tag_type;

   function automatic logic [W:0] saturate(input logic neg, input logic [MAGW-1:0] mag);
      logic [MAGW-1:0] m;
      logic            ovf;
      m   = mag;
      ovf = 1'b0;
      if (!neg && mag > POS_LIM) begin
         m   = POS_LIM;
         ovf = 1'b1;
      end else if (neg && mag > NEG_LIM) begin
         m   = NEG_LIM;
         ovf = 1'b1;
      end
      return {ovf, neg ? W'(-m) : W'(m)};
   endfunction

   logic en;
   assign en        = !(rsp_valid && rsp_stall);
   assign req_stall = !en;

   // stage 1: operand capture
   logic                s1_valid_ff;
   cmd_type             s1_cmd_ff;
   logic signed [W-1:0] s1_ar_ff, s1_ai_ff, s1_br_ff, s1_bi_ff;

   // stage 2: products
   logic                 s2_valid_ff;
   cmd_type              s2_cmd_ff;
   logic                 s2_eq_ff, s2_eq_in;
   logic signed [W-1:0]  s2_ar_ff, s2_ai_ff, s2_br_ff, s2_bi_ff;
   logic signed [PW-1:0] s2_rr_ff, s2_ii_ff, s2_ri_ff, s2_ir_ff;
   logic signed [PW-1:0] s2_aa_ff, s2_a2_ff, s2_b1_ff, s2_b2_ff;
   logic signed [PW-1:0] s2_rr_in, s2_ii_in, s2_ri_in, s2_ir_in;
   logic signed [PW-1:0] s2_aa_in, s2_a2_in, s2_b1_in, s2_b2_in;

   // stage 3: exact signed sums
   logic                 s3_valid_ff;
   logic signed [SW-1:0] s3_re_ff, s3_im_ff, s3_re_in, s3_im_in;
   logic [PW-1:0]        s3_den_ff, s3_den_in;
   logic                 s3_eq_ff, s3_dz_ff, s3_div_ff, s3_shift_ff;
   logic                 s3_dz_in, s3_div_in, s3_shift_in;

   // stage 4: sign and magnitude
   logic                 s4_valid_ff;
   tag_type              s4_tag_ff, s4_tag_in;
   logic [PW-1:0]        s4_den_ff;

   always_comb begin
      s2_rr_in = s1_ar_ff * s1_br_ff;
      s2_ii_in = s1_ai_ff * s1_bi_ff;
      s2_ri_in = s1_ar_ff * s1_bi_ff;
      s2_ir_in = s1_ai_ff * s1_br_ff;
      s2_aa_in = s1_ar_ff * s1_ar_ff;
      s2_a2_in = s1_ai_ff * s1_ai_ff;
      s2_b1_in = s1_br_ff * s1_br_ff;
      s2_b2_in = s1_bi_ff * s1_bi_ff;
      s2_eq_in = (s1_cmd_ff == CMD_EQ) && (s1_ar_ff == s1_br_ff) && (s1_ai_ff == s1_bi_ff);
   end

   always_comb begin
      logic signed [SW-1:0] den_sum;
      den_sum     = SW'(s2_b1_ff) + SW'(s2_b2_ff);
      s3_den_in   = den_sum[PW-1:0];
      s3_dz_in    = (s2_cmd_ff == CMD_DIV) && (s3_den_in == '0);
      s3_div_in   = (s2_cmd_ff == CMD_DIV) && !s3_dz_in;
      s3_shift_in = (s2_cmd_ff == CMD_MUL) || (s2_cmd_ff == CMD_MOD);
      s3_re_in    = '0;
      s3_im_in    = '0;
      case (s2_cmd_ff)
         CMD_ADD: begin
            s3_re_in = SW'(s2_ar_ff) + SW'(s2_br_ff);
            s3_im_in = SW'(s2_ai_ff) + SW'(s2_bi_ff);
         end
         CMD_SUB: begin
            s3_re_in = SW'(s2_ar_ff) - SW'(s2_br_ff);
            s3_im_in = SW'(s2_ai_ff) - SW'(s2_bi_ff);
         end
         CMD_MUL: begin
            s3_re_in = SW'(s2_rr_ff) - SW'(s2_ii_ff);
            s3_im_in = SW'(s2_ri_ff) + SW'(s2_ir_ff);
         end
         CMD_DIV: begin
            if (!s3_dz_in) begin
               s3_re_in = SW'(s2_rr_ff) + SW'(s2_ii_ff);
               s3_im_in = SW'(s2_ir_ff) - SW'(s2_ri_ff);
            end
         end
         CMD_CONJ: begin
            s3_re_in = SW'(s2_ar_ff);
            s3_im_in = -SW'(s2_ai_ff);
         end
         CMD_MOD: begin
            s3_re_in = SW'(s2_aa_ff) + SW'(s2_a2_ff);
         end
         default: begin
            s3_re_in = '0;
            s3_im_in = '0;
         end
      endcase
   end

   always_comb begin
      logic signed [SW-1:0] abs_re, abs_im;
      abs_re           = s3_re_ff[SW-1] ? -s3_re_ff : s3_re_ff;
      abs_im           = s3_im_ff[SW-1] ? -s3_im_ff : s3_im_ff;
      s4_tag_in.is_div = s3_div_ff;
      s4_tag_in.eq     = s3_eq_ff;
      s4_tag_in.dz     = s3_dz_ff;
      s4_tag_in.neg_re = s3_re_ff[SW-1];
      s4_tag_in.neg_im = s3_im_ff[SW-1];
      // truncation toward zero works on the magnitude
      s4_tag_in.mag_re = s3_shift_ff ? (MAGW'(abs_re) >> FRAC_BITS) : MAGW'(abs_re);
      s4_tag_in.mag_im = s3_shift_ff ? (MAGW'(abs_im) >> FRAC_BITS) : MAGW'(abs_im);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
         s2_valid_ff <= 1'b0;
         s3_valid_ff <= 1'b0;
         s4_valid_ff <= 1'b0;
      end else if (en) begin
         s1_valid_ff <= req_valid;
         s2_valid_ff <= s1_valid_ff;
         s3_valid_ff <= s2_valid_ff;
         s4_valid_ff <= s3_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         s1_cmd_ff   <= cmd_type'(req_command);
         s1_ar_ff    <= req_a_real;
         s1_ai_ff    <= req_a_imag;
         s1_br_ff    <= req_b_real;
         s1_bi_ff    <= req_b_imag;
         s2_cmd_ff   <= s1_cmd_ff;
         s2_eq_ff    <= s2_eq_in;
         s2_ar_ff    <= s1_ar_ff;
         s2_ai_ff    <= s1_ai_ff;
         s2_br_ff    <= s1_br_ff;
         s2_bi_ff    <= s1_bi_ff;
         s2_rr_ff    <= s2_rr_in;
         s2_ii_ff    <= s2_ii_in;
         s2_ri_ff    <= s2_ri_in;
         s2_ir_ff    <= s2_ir_in;
         s2_aa_ff    <= s2_aa_in;
         s2_a2_ff    <= s2_a2_in;
         s2_b1_ff    <= s2_b1_in;
         s2_b2_ff    <= s2_b2_in;
         s3_re_ff    <= s3_re_in;
         s3_im_ff    <= s3_im_in;
         s3_den_ff   <= s3_den_in;
         s3_eq_ff    <= s2_eq_ff;
         s3_dz_ff    <= s3_dz_in;
         s3_div_ff   <= s3_div_in;
         s3_shift_ff <= s3_shift_in;
         s4_tag_ff   <= s4_tag_in;
         s4_den_ff   <= s3_den_ff;
      end
   end

   // divider lanes: real and imaginary numerators over the shared divisor
   logic [PW-1:0]  div_num [2];
   logic           div_valid;
   logic [$bits(tag_type)-1:0] div_tag_bits;
   tag_type        div_tag;
   logic [W:0]     div_q   [2];
   logic           div_big [2];

   assign div_num[0] = s4_tag_ff.mag_re[PW-1:0];
   assign div_num[1] = s4_tag_ff.mag_im[PW-1:0];

   cau_divider #(
      .PART_WIDTH(PART_WIDTH),
      .FRAC_BITS (FRAC_BITS),
      .TAG_WIDTH ($bits(tag_type))
   ) u_div (
      .clock    (clock),
      .reset    (reset),
      .en       (en),
      .in_valid (s4_valid_ff),
      .in_tag   (s4_tag_ff),
      .in_num   (div_num),
      .in_den   (s4_den_ff),
      .out_valid(div_valid),
      .out_tag  (div_tag_bits),
      .out_q    (div_q),
      .out_big  (div_big)
   );

   assign div_tag = tag_type'(div_tag_bits);

   // output register
   logic                rsp_valid_ff;
   logic signed [W-1:0] rsp_re_ff, rsp_im_ff, rsp_re_in, rsp_im_in;
   logic                rsp_eq_ff, rsp_dz_ff, rsp_ovf_ff, rsp_ovf_in;

   always_comb begin
      logic [MAGW-1:0] m_re, m_im;
      logic [W:0]      sr, si;
      m_re = div_tag.mag_re;
      m_im = div_tag.mag_im;
      if (div_tag.is_div) begin
         m_re = div_big[0] ? NEG_LIM + MAGW'(1) : MAGW'(div_q[0]);
         m_im = div_big[1] ? NEG_LIM + MAGW'(1) : MAGW'(div_q[1]);
      end
      sr         = saturate(div_tag.neg_re, m_re);
      si         = saturate(div_tag.neg_im, m_im);
      rsp_re_in  = sr[W-1:0];
      rsp_im_in  = si[W-1:0];
      rsp_ovf_in = sr[W] || si[W];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (en) begin
         rsp_valid_ff <= div_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         rsp_re_ff  <= rsp_re_in;
         rsp_im_ff  <= rsp_im_in;
         rsp_eq_ff  <= div_tag.eq;
         rsp_dz_ff  <= div_tag.dz;
         rsp_ovf_ff <= rsp_ovf_in;
      end
   end

   assign rsp_valid    = rsp_valid_ff;
   assign rsp_res_real = rsp_re_ff;
   assign rsp_res_imag = rsp_im_ff;
   assign rsp_is_equal = rsp_eq_ff;
   assign rsp_div_zero = rsp_dz_ff;
   assign rsp_overflow = rsp_ovf_ff;

   // zero divisor gives a clean zero result
   a_dz_no_ovf: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_div_zero |-> !rsp_overflow && rsp_res_real == '0 && rsp_res_imag == '0)
      else $error("zero divisor beat carries overflow or a non-zero result");

   // equality beats carry no arithmetic result
   a_eq_clean: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_is_equal |-> !rsp_div_zero && !rsp_overflow && rsp_res_real == '0)
      else $error("equality beat carries other result fields");

   // a held result blocks the input side
   a_stall_link: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |-> req_stall)
      else $error("input accepted while result is held");

endmodule

`default_nettype wire

// ===== design/cau_divider.sv =====
// pipelined two-lane restoring divider, one quotient bit per stage, shared divisor
`default_nettype none

module cau_divider #(
   parameter int PART_WIDTH = cau_pkg::PART_WIDTH_DEF,
   parameter int FRAC_BITS  = cau_pkg::FRAC_BITS_DEF,
   parameter int TAG_WIDTH  = 1
) (
   input  wire logic                      clock,
   input  wire logic                      reset,
   input  wire logic                      en,
   input  wire logic                      in_valid,
   input  wire logic [TAG_WIDTH-1:0]      in_tag,
   input  wire logic [2*PART_WIDTH-1:0]   in_num [2],
   input  wire logic [2*PART_WIDTH-1:0]   in_den,
   output logic                           out_valid,
   output logic [TAG_WIDTH-1:0]           out_tag,
   output logic [PART_WIDTH:0]            out_q [2],
   output logic                           out_big [2]
);

   localparam int NUMW = 2 * PART_WIDTH;
   localparam int K    = PART_WIDTH + 1;
   localparam int NW   = NUMW + FRAC_BITS;

   logic [K:0]           valid_ff, valid_in;
   logic [TAG_WIDTH-1:0] tag_ff  [0:K];
   logic [TAG_WIDTH-1:0] tag_in  [0:K];
   logic [NUMW-1:0]      den_ff  [0:K];
   logic [NUMW-1:0]      den_in  [0:K];
   logic [NUMW-1:0]      rem_ff  [0:K][2];
   logic [NUMW-1:0]      rem_in  [0:K][2];
   logic [K-1:0]         low_ff  [0:K][2];
   logic [K-1:0]         low_in  [0:K][2];
   logic [K-1:0]         q_ff    [0:K][2];
   logic [K-1:0]         q_in    [0:K][2];
   logic                 big_ff  [0:K][2];
   logic                 big_in  [0:K][2];

   always_comb begin
      logic [NW-1:0]   n_full;
      logic [NW-1:0]   n_hi;
      logic [NUMW:0]   rr;
      logic [NUMW:0]   diff;
      logic            ge;
      valid_in[0] = in_valid;
      tag_in[0]   = in_tag;
      den_in[0]   = in_den;
      for (int l = 0; l < 2; l++) begin
         n_full = NW'(in_num[l]) << FRAC_BITS;
         n_hi   = n_full >> K;
         // quotient would not fit in K bits
         big_in[0][l] = n_hi >= NW'(in_den);
         rem_in[0][l] = n_hi[NUMW-1:0];
         low_in[0][l] = n_full[K-1:0];
         q_in[0][l]   = '0;
      end
      for (int s = 1; s <= K; s++) begin
         valid_in[s] = valid_ff[s-1];
         tag_in[s]   = tag_ff[s-1];
         den_in[s]   = den_ff[s-1];
         for (int l = 0; l < 2; l++) begin
            rr   = {rem_ff[s-1][l], low_ff[s-1][l][K-1]};
            diff = rr - {1'b0, den_ff[s-1]};
            ge   = rr >= {1'b0, den_ff[s-1]};
            rem_in[s][l] = ge ? diff[NUMW-1:0] : rr[NUMW-1:0];
            q_in[s][l]   = {q_ff[s-1][l][K-2:0], ge};
            low_in[s][l] = low_ff[s-1][l] << 1;
            big_in[s][l] = big_ff[s-1][l];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else if (en) begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         tag_ff <= tag_in;
         den_ff <= den_in;
         rem_ff <= rem_in;
         low_ff <= low_in;
         q_ff   <= q_in;
         big_ff <= big_in;
      end
   end

   assign out_valid  = valid_ff[K];
   assign out_tag    = tag_ff[K];
   assign out_q[0]   = q_ff[K][0];
   assign out_q[1]   = q_ff[K][1];
   assign out_big[0] = big_ff[K][0];
   assign out_big[1] = big_ff[K][1];

endmodule

`default_nettype wire
